### hdl/rbst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbst_pkg
// shared types and constants for the ray against box slab test unit
// ----------------------------------------------------------------------------
package rbst_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int DATA_W        = 32;
   localparam int CSR_ADDR_W    = 5;

   // register indexes
   localparam logic [2:0] REG_BOX_MIN_X = 3'd0;
   localparam logic [2:0] REG_BOX_MIN_Y = 3'd1;
   localparam logic [2:0] REG_BOX_MIN_Z = 3'd2;
   localparam logic [2:0] REG_BOX_MAX_X = 3'd3;
   localparam logic [2:0] REG_BOX_MAX_Y = 3'd4;
   localparam logic [2:0] REG_BOX_MAX_Z = 3'd5;

   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic signed [31:0] dir_x;
      logic signed [31:0] dir_y;
      logic signed [31:0] dir_z;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] t_enter;
      logic signed [31:0] t_exit;
   } rsp_type;

endpackage
`default_nettype wire

### hdl/ray_box_slab_test_unit.sv
`default_nettype none
// request to result: reciprocal, slab and interval stages in that order, all registered
// throughput: one request per cycle while the result side is not stalled; the divider adds one quotient bit a stage
// a stall on the result side freezes the whole pipeline in place
// reset: synchronous, clears valid bits and box registers to zero
// ----------------------------------------------------------------------------
// ray_box_slab_test_unit
// ray against axis-aligned box slab test, signed fixed point, fully pipelined
// ----------------------------------------------------------------------------
module ray_box_slab_test_unit #(
   parameter int FRAC_BITS = rbst_pkg::FRAC_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire rbst_pkg::req_type                  req_data,
   // result channel
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output rbst_pkg::rsp_type                       rsp_data,
   // register port
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [rbst_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [rbst_pkg::DATA_W-1:0]        pwdata,
   output logic [rbst_pkg::DATA_W-1:0]             prdata,
   output logic                                    pready
);
   import rbst_pkg::*;

   // divider: input reg, one stage per quotient bit, output reg
   localparam int RECIP_LAT = 2 * FRAC_BITS + 3;
   // slab: distance, product, shift, order
   localparam int SLAB_LAT  = 4;
   // interval: y narrowing, z narrowing and result
   localparam int INT_LAT   = 2;
   localparam int TOTAL_LAT = RECIP_LAT + SLAB_LAT + INT_LAT;

   logic signed [31:0] box_ff [0:5];
   logic [2:0]         reg_idx;
   logic               wr_en;
   logic               en;

   logic [TOTAL_LAT-1:0] vld_ff;
   req_type              org_ff [0:RECIP_LAT-1];

   logic signed [31:0] r_x, r_y, r_z;
   logic signed [31:0] tx0, tx1, ty0, ty1, tz0, tz1;

   // register port, always ready
   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];
   assign wr_en   = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            box_ff[i] <= '0;
         end
      end else if (wr_en) begin
         case (reg_idx)
            REG_BOX_MIN_X: box_ff[0] <= pwdata;
            REG_BOX_MIN_Y: box_ff[1] <= pwdata;
            REG_BOX_MIN_Z: box_ff[2] <= pwdata;
            REG_BOX_MAX_X: box_ff[3] <= pwdata;
            REG_BOX_MAX_Y: box_ff[4] <= pwdata;
            REG_BOX_MAX_Z: box_ff[5] <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_BOX_MIN_X: prdata = box_ff[0];
         REG_BOX_MIN_Y: prdata = box_ff[1];
         REG_BOX_MIN_Z: prdata = box_ff[2];
         REG_BOX_MAX_X: prdata = box_ff[3];
         REG_BOX_MAX_Y: prdata = box_ff[4];
         REG_BOX_MAX_Z: prdata = box_ff[5];
         default:       prdata = '0;
      endcase
   end

   // the pipeline moves unless a finished result is held up
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // valid bits travel alongside the data stages
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[TOTAL_LAT-2:0], req_valid};
      end
   end

   assign rsp_valid = vld_ff[TOTAL_LAT-1];

   // origins wait for the reciprocals
   always_ff @(posedge clock) begin
      if (en) begin
         org_ff[0] <= req_data;
         for (int i = 1; i < RECIP_LAT; i++) begin
            org_ff[i] <= org_ff[i-1];
         end
      end
   end

   // reciprocal of each direction component
   rbst_recip #(.FRAC_BITS(FRAC_BITS)) u_recip_x (
      .clock(clock), .en(en), .d(req_data.dir_x), .r(r_x));
   rbst_recip #(.FRAC_BITS(FRAC_BITS)) u_recip_y (
      .clock(clock), .en(en), .d(req_data.dir_y), .r(r_y));
   rbst_recip #(.FRAC_BITS(FRAC_BITS)) u_recip_z (
      .clock(clock), .en(en), .d(req_data.dir_z), .r(r_z));

   // entry and exit parameters per axis
   rbst_slab #(.FRAC_BITS(FRAC_BITS)) u_slab_x (
      .clock(clock), .en(en), .plane_min(box_ff[0]), .plane_max(box_ff[3]),
      .origin(org_ff[RECIP_LAT-1].origin_x), .r(r_x), .t_near(tx0), .t_far(tx1));
   rbst_slab #(.FRAC_BITS(FRAC_BITS)) u_slab_y (
      .clock(clock), .en(en), .plane_min(box_ff[1]), .plane_max(box_ff[4]),
      .origin(org_ff[RECIP_LAT-1].origin_y), .r(r_y), .t_near(ty0), .t_far(ty1));
   rbst_slab #(.FRAC_BITS(FRAC_BITS)) u_slab_z (
      .clock(clock), .en(en), .plane_min(box_ff[2]), .plane_max(box_ff[5]),
      .origin(org_ff[RECIP_LAT-1].origin_z), .r(r_z), .t_near(tz0), .t_far(tz1));

   // interval narrowing, its last register is the result register
   rbst_interval u_interval (
      .clock(clock), .en(en),
      .tx0(tx0), .tx1(tx1), .ty0(ty0), .ty1(ty1), .tz0(tz0), .tz1(tz1),
      .result(rsp_data));

`ifndef SYNTHESIS
   // a miss carries zero parameters
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.hit |-> rsp_data.t_enter == 32'sd0 && rsp_data.t_exit == 32'sd0)
      else $error("miss with nonzero parameters");

   // a hit has an ordered interval
   a_hit_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit |-> rsp_data.t_enter <= rsp_data.t_exit)
      else $error("hit with entry after exit");

   // input is held exactly when a result is held
   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("request stall out of step with result stall");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
`endif

endmodule
`default_nettype wire

### hdl/rbst_recip.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbst_recip
// pipelined restoring divider, 2^(2*frac) / d, one quotient bit per stage
// ----------------------------------------------------------------------------
module rbst_recip #(
   parameter int FRAC_BITS = rbst_pkg::FRAC_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic signed [31:0] d,
   output logic signed [31:0]      r
);
   import rbst_pkg::*;

   localparam int QW = 2 * FRAC_BITS + 1;

   logic [31:0]    mag_ff  [0:QW];
   logic [31:0]    rem_ff  [0:QW];
   logic [QW-1:0]  q_ff    [0:QW];
   logic           neg_ff  [0:QW];
   logic           zero_ff [0:QW];
   logic signed [31:0] r_ff;
   logic signed [31:0] r_in;
   logic [63:0]    qx;

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff[0]  <= d[31] ? 32'(-d) : 32'(d);
         rem_ff[0]  <= '0;
         q_ff[0]    <= '0;
         neg_ff[0]  <= d[31];
         zero_ff[0] <= (d == 32'sd0);
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [32:0] rem_sh;
      logic        ge;
      assign rem_sh = {rem_ff[k], (k == 0) ? 1'b1 : 1'b0};
      assign ge     = rem_sh >= {1'b0, mag_ff[k]};
      always_ff @(posedge clock) begin
         if (en) begin
            mag_ff[k+1]  <= mag_ff[k];
            rem_ff[k+1]  <= ge ? 32'(rem_sh - {1'b0, mag_ff[k]}) : rem_sh[31:0];
            q_ff[k+1]    <= {q_ff[k][QW-2:0], ge};
            neg_ff[k+1]  <= neg_ff[k];
            zero_ff[k+1] <= zero_ff[k];
         end
      end
   end

   assign qx = 64'(q_ff[QW]);

   always_comb begin
      if (zero_ff[QW]) begin
         r_in = S32_MAX;
      end else if (neg_ff[QW]) begin
         r_in = (qx > 64'h8000_0000) ? S32_MIN : 32'(-qx[31:0]);
      end else begin
         r_in = (qx > 64'h7FFF_FFFF) ? S32_MAX : qx[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff <= r_in;
      end
   end

   assign r = r_ff;

endmodule
`default_nettype wire

### hdl/rbst_slab.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbst_slab
// one axis: plane distances, scale by reciprocal, floor shift, order pair
// ----------------------------------------------------------------------------
module rbst_slab #(
   parameter int FRAC_BITS = rbst_pkg::FRAC_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic signed [31:0] plane_min,
   input  wire logic signed [31:0] plane_max,
   input  wire logic signed [31:0] origin,
   input  wire logic signed [31:0] r,
   output logic signed [31:0]      t_near,
   output logic signed [31:0]      t_far
);
   import rbst_pkg::*;

   logic signed [32:0] dm, dx;
   logic signed [31:0] e0_in, e1_in;
   logic signed [31:0] e0_ff, e1_ff, r_ff;
   logic signed [63:0] p0_ff, p1_ff;
   logic signed [63:0] s0, s1;
   logic signed [31:0] t0_in, t1_in, t0_ff, t1_ff;
   logic signed [31:0] near_ff, far_ff;

   assign dm = {plane_min[31], plane_min} - {origin[31], origin};
   assign dx = {plane_max[31], plane_max} - {origin[31], origin};

   // saturate the 33-bit distance
   assign e0_in = (dm[32] != dm[31]) ? (dm[32] ? S32_MIN : S32_MAX) : dm[31:0];
   assign e1_in = (dx[32] != dx[31]) ? (dx[32] ? S32_MIN : S32_MAX) : dx[31:0];

   // arithmetic shift is floor division by a power of two
   assign s0 = p0_ff >>> FRAC_BITS;
   assign s1 = p1_ff >>> FRAC_BITS;

   assign t0_in = (s0 > 64'(S32_MAX)) ? S32_MAX :
                  (s0 < 64'(S32_MIN)) ? S32_MIN : s0[31:0];
   assign t1_in = (s1 > 64'(S32_MAX)) ? S32_MAX :
                  (s1 < 64'(S32_MIN)) ? S32_MIN : s1[31:0];

   always_ff @(posedge clock) begin
      if (en) begin
         e0_ff <= e0_in;
         e1_ff <= e1_in;
         r_ff  <= r;
         p0_ff <= e0_ff * r_ff;
         p1_ff <= e1_ff * r_ff;
         t0_ff <= t0_in;
         t1_ff <= t1_in;
         if (t0_ff > t1_ff) begin
            near_ff <= t1_ff;
            far_ff  <= t0_ff;
         end else begin
            near_ff <= t0_ff;
            far_ff  <= t1_ff;
         end
      end
   end

   assign t_near = near_ff;
   assign t_far  = far_ff;

endmodule
`default_nettype wire

### hdl/rbst_interval.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbst_interval
// narrows the entry and exit interval over y then z, forms the result
// ----------------------------------------------------------------------------
module rbst_interval (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic signed [31:0] tx0,
   input  wire logic signed [31:0] tx1,
   input  wire logic signed [31:0] ty0,
   input  wire logic signed [31:0] ty1,
   input  wire logic signed [31:0] tz0,
   input  wire logic signed [31:0] tz1,
   output rbst_pkg::rsp_type       result
);
   import rbst_pkg::*;

   logic               hit1_ff;
   logic signed [31:0] lo1_ff, hi1_ff, tz0_ff, tz1_ff;
   rsp_type            res_ff;
   logic               hit2;

   assign hit2 = hit1_ff && !(lo1_ff > tz1_ff || hi1_ff < tz0_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         hit1_ff <= !(tx0 > ty1 || tx1 < ty0);
         lo1_ff  <= (ty0 > tx0) ? ty0 : tx0;
         hi1_ff  <= (ty1 < tx1) ? ty1 : tx1;
         tz0_ff  <= tz0;
         tz1_ff  <= tz1;
         res_ff.hit     <= hit2;
         res_ff.t_enter <= !hit2 ? 32'sd0 : ((tz0_ff > lo1_ff) ? tz0_ff : lo1_ff);
         res_ff.t_exit  <= !hit2 ? 32'sd0 : ((tz1_ff < hi1_ff) ? tz1_ff : hi1_ff);
      end
   end

   assign result = res_ff;

endmodule
`default_nettype wire
